// ===== rtl/dhk_pkg.sv =====
// Package for the differential heading keeper: constants, register codes and the root table.
`timescale 1ns / 1ps

package dhk_pkg;

    localparam int ROOT_DEPTH = 256;
    localparam int ROOT_IDX_W = $clog2(ROOT_DEPTH);
    localparam int ROOT_W     = 16;
    localparam int SPEED_MAX  = 255;

    // Denominator of the bin lower edge over three, scaled to the table depth.
    localparam logic [63:0] ROOT_DIV = 64'(6 * ROOT_DEPTH);

    // Heading thresholds in Q2.14 half-turns.
    localparam logic [14:0] NEAR_LIM = 15'd163;
    localparam logic [14:0] FAR_LIM  = 15'd14746;
    localparam logic [14:0] HALF_LIM = 15'd8192;
    localparam logic [14:0] ONE_Q14  = 15'd16384;

    localparam logic [2:0] CFG_OVERRIDE = 3'd0;
    localparam logic [2:0] CFG_TARGET   = 3'd1;
    localparam logic [2:0] CFG_CRUISE   = 3'd2;
    localparam logic [2:0] CFG_MIN      = 3'd3;
    localparam logic [2:0] CFG_TURN     = 3'd4;

    typedef logic [ROOT_DEPTH-1:0][ROOT_W-1:0] t_root_tab;

    // Entry i is the truncated cube root of the lower bin edge over three, in Q1.15.
    // The cube is scaled up by the denominator rather than dividing the edge down,
    // which gives the same largest root.
    function automatic t_root_tab root_table();
        t_root_tab   tab;
        logic [63:0] edge_q;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < ROOT_DEPTH; i++) begin
            edge_q = 64'(i) << 45;
            lo     = 64'd0;
            hi     = 64'd32768;
            for (int k = 0; k < 17; k++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    if (mid * mid * mid * ROOT_DIV <= edge_q) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            tab[i] = lo[ROOT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = root_table();

endpackage

// ===== rtl/differential_heading_keeper_top.sv =====
// Heading hold for a skid-steered vehicle: error wrap, mode decision and motor commands.
// Data path: a heading taken on a transfer lands in the input register, and its result
// is registered in the result register once the output is not stalled.
// Throughput: one heading per cycle while the output is not stalled; the only loop is
// the stored left/right command pair, read and updated within the single compute stage.
// Reset: synchronous, active low; clears the valid flags of both stages, the stored
// commands and the configuration registers to their defaults.
`timescale 1ns / 1ps

module differential_heading_keeper_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic signed [15:0] i_heading,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [8:0] o_left_cmd,
    output logic signed [8:0] o_right_cmd,
    output logic              o_cmd_valid,
    output logic              o_on_target,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int IW = dhk_pkg::ROOT_IDX_W;
    localparam logic signed [9:0] SMAX = 10'(dhk_pkg::SPEED_MAX);

    logic               r_override;
    logic signed [15:0] r_target;
    logic signed [8:0]  r_cruise;
    logic [7:0]         r_min_speed;
    logic [7:0]         r_turn_speed;

    logic               r_in_valid;
    logic signed [15:0] r_heading;
    logic               r_out_valid;
    logic               r_cmd_valid;
    logic               r_on_target;
    logic signed [8:0]  r_left_speed;
    logic signed [8:0]  r_right_speed;

    logic               advance;
    logic signed [16:0] diff;
    logic [14:0]        m;
    logic signed [15:0] err;
    logic [14:0]        a;
    logic signed [9:0]  cruise_x;
    logic signed [8:0]  spd;
    logic [7:0]         sm;
    logic [7:0]         ts;
    logic signed [8:0]  ts_pos;
    logic signed [8:0]  ts_neg;
    logic [15+IW-1:0]   idx_full;
    logic [IW-1:0]      idx;
    logic [dhk_pkg::ROOT_W-1:0] root;
    logic [16:0]        factor;
    logic [24:0]        prod;
    logic [7:0]         mag_raw;
    logic [7:0]         mn;
    logic [7:0]         mag;
    logic signed [8:0]  slow;
    logic               n_cmd_valid;
    logic               n_on_target;
    logic signed [8:0]  n_left_speed;
    logic signed [8:0]  n_right_speed;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override   <= 1'b0;
            r_target     <= 16'sd16384;
            r_cruise     <= 9'sd0;
            r_min_speed  <= 8'd0;
            r_turn_speed <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dhk_pkg::CFG_OVERRIDE: r_override   <= i_cfg_data[0];
                dhk_pkg::CFG_TARGET:   r_target     <= i_cfg_data;
                dhk_pkg::CFG_CRUISE:   r_cruise     <= i_cfg_data[8:0];
                dhk_pkg::CFG_MIN:      r_min_speed  <= i_cfg_data[7:0];
                dhk_pkg::CFG_TURN:     r_turn_speed <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Error wrapped modulo 2.0 into (-1, 1].
    always_comb begin
        diff = 17'(r_heading) - 17'(r_target);
        m    = diff[14:0];
        err  = {(m > dhk_pkg::ONE_Q14), m};
        a    = err[15] ? 15'(-err) : err[14:0];
    end

    always_comb begin
        cruise_x = 10'(r_cruise);
        priority if (cruise_x > SMAX) begin
            spd = 9'(SMAX);
        end else if (cruise_x < -SMAX) begin
            spd = 9'(-SMAX);
        end else begin
            spd = r_cruise;
        end
        sm     = spd[8] ? 8'(-spd) : spd[7:0];
        ts     = (10'(r_turn_speed) > SMAX) ? 8'(SMAX) : r_turn_speed;
        ts_pos = $signed({1'b0, ts});
        ts_neg = -ts_pos;
        mn     = (10'(r_min_speed) > SMAX) ? 8'(SMAX) : r_min_speed;
    end

    // Slowed side: |speed| * (1 - cbrt(|e|/3)), truncated and floored at the minimum.
    always_comb begin
        idx_full = {a, {IW{1'b0}}} >> 13;
        idx      = (idx_full > (15+IW)'(dhk_pkg::ROOT_DEPTH - 1))
                   ? IW'(dhk_pkg::ROOT_DEPTH - 1) : idx_full[IW-1:0];
        root     = dhk_pkg::ROOT_TAB[idx];
        factor   = 17'd32768 - 17'(root);
        prod     = 25'(sm) * 25'(factor);
        mag_raw  = 8'(prod >> 15);
        mag      = (mag_raw < mn) ? mn : mag_raw;
        slow     = spd[8] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb begin
        n_left_speed  = r_left_speed;
        n_right_speed = r_right_speed;
        n_cmd_valid   = 1'b0;
        n_on_target   = 1'b0;
        priority if (r_override) begin
            n_on_target = 1'b1;
        end else if (spd == 9'sd0) begin
            priority if (a <= dhk_pkg::NEAR_LIM) begin
                n_left_speed  = 9'sd0;
                n_right_speed = 9'sd0;
                n_cmd_valid   = 1'b1;
                n_on_target   = 1'b1;
            end else if (a >= dhk_pkg::FAR_LIM
                         && (r_left_speed != 9'sd0 || r_right_speed != 9'sd0)) begin
                // Likely a wrap glitch while rotating: keep the current commands.
            end else if (err[15]) begin
                n_left_speed  = ts_pos;
                n_right_speed = ts_neg;
                n_cmd_valid   = 1'b1;
            end else begin
                n_left_speed  = ts_neg;
                n_right_speed = ts_pos;
                n_cmd_valid   = 1'b1;
            end
        end else if (a >= dhk_pkg::FAR_LIM && r_left_speed != r_right_speed) begin
            // Already turning hard: hold.
        end else if (a > dhk_pkg::HALF_LIM) begin
            n_cmd_valid = 1'b1;
            if (!err[15]) begin
                n_left_speed  = ts_neg;
                n_right_speed = ts_pos;
            end else begin
                n_left_speed  = ts_pos;
                n_right_speed = ts_neg;
            end
        end else begin
            n_on_target = (a <= dhk_pkg::NEAR_LIM);
            priority if (err[15]) begin
                n_left_speed  = spd;
                n_right_speed = slow;
                n_cmd_valid   = 1'b1;
            end else if (err != 16'sd0) begin
                n_left_speed  = slow;
                n_right_speed = spd;
                n_cmd_valid   = 1'b1;
            end else begin
                n_on_target = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left_speed  <= 9'sd0;
            r_right_speed <= 9'sd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_left_speed  <= n_left_speed;
                r_right_speed <= n_right_speed;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_heading <= i_heading;
        end
        if (advance) begin
            r_cmd_valid <= n_cmd_valid;
            r_on_target <= n_on_target;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_cmd  = r_left_speed;
    assign o_right_cmd = r_right_speed;
    assign o_cmd_valid = r_cmd_valid;
    assign o_on_target = r_on_target;

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled while the result register is empty");

    a_override_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_override |=> o_out_valid && !o_cmd_valid && o_on_target)
        else $error("override produced a command or missed on-target");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_cmd != 9'sh100 && o_right_cmd != 9'sh100)
        else $error("motor command outside the speed range");

    a_hold_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !n_cmd_valid |=> $stable(o_left_cmd) && $stable(o_right_cmd))
        else $error("stored commands changed on a transfer without a command");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the differential heading keeper: directed table, random phases.
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int ONE_Q15     = 32768;
    localparam int PHASES      = 19;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
        logic              issued;
        logic              on_tgt;
    } t_cmd;

    typedef struct packed {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [15:0] data;
        bit          typed;
        t_cmd        want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic signed [15:0] i_heading = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [8:0] o_left_cmd;
    logic signed [8:0] o_right_cmd;
    logic              o_cmd_valid;
    logic              o_on_target;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;

    // Shadow of the configuration registers and of the stored motor commands.
    logic               cfg_override;
    logic signed [15:0] cfg_target;
    logic signed [8:0]  cfg_cruise;
    logic [7:0]         cfg_min;
    logic [7:0]         cfg_turn;
    logic signed [8:0]  held_left;
    logic signed [8:0]  held_right;

    int   cube_root [dhk_pkg::ROOT_DEPTH];
    t_cmd pending_cmds [$];
    int   bad_count = 0;
    int   quiet_cycles = 0;
    bit   no_gaps = 1'b0;
    bit   long_hold_req = 1'b0;

    differential_heading_keeper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_heading   (i_heading),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_left_cmd  (o_left_cmd),
        .o_right_cmd (o_right_cmd),
        .o_cmd_valid (o_cmd_valid),
        .o_on_target (o_on_target),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Works out the motor commands for one heading and updates the stored pair.
    function automatic t_cmd steer_predict(logic signed [15:0] hdg);
        int   err;
        int   mag_err;
        int   spd;
        int   ts;
        int   nl;
        int   nr;
        int   sm;
        int   mag;
        int   slow;
        int   idx;
        logic issue;
        logic near;
        t_cmd res;
        err = int'(hdg) - int'(cfg_target);
        // The error is taken modulo two half-turns into (-1, 1].
        err = int'(err[14:0]);
        if (err > int'(dhk_pkg::ONE_Q14)) begin
            err = err - 2 * int'(dhk_pkg::ONE_Q14);
        end
        mag_err = err < 0 ? -err : err;
        spd = int'(cfg_cruise);
        if (spd < -dhk_pkg::SPEED_MAX) begin
            spd = -dhk_pkg::SPEED_MAX;
        end
        ts = int'(cfg_turn);
        nl = int'(held_left);
        nr = int'(held_right);
        issue = 1'b0;
        near = 1'b0;
        if (cfg_override) begin
            near = 1'b1;
        end else if (spd == 0) begin
            if (mag_err <= int'(dhk_pkg::NEAR_LIM)) begin
                nl = 0;
                nr = 0;
                issue = 1'b1;
                near = 1'b1;
            end else if (mag_err >= int'(dhk_pkg::FAR_LIM)
                         && (held_left != 0 || held_right != 0)) begin
                // Close to a half-turn away while moving: keep going as before.
            end else if (err < 0) begin
                nl = ts;
                nr = -ts;
                issue = 1'b1;
            end else begin
                nl = -ts;
                nr = ts;
                issue = 1'b1;
            end
        end else if (mag_err >= int'(dhk_pkg::FAR_LIM) && held_left != held_right) begin
            // Already turning near a half-turn off: hold the commands.
        end else if (mag_err > int'(dhk_pkg::HALF_LIM)) begin
            if (err > 0) begin
                nl = -ts;
                nr = ts;
            end else begin
                nl = ts;
                nr = -ts;
            end
            issue = 1'b1;
        end else begin
            // The table spans half a half-turn of error; the top edge is clamped into the last bin.
            idx = (mag_err * dhk_pkg::ROOT_DEPTH) >> 13;
            if (idx > dhk_pkg::ROOT_DEPTH - 1) begin
                idx = dhk_pkg::ROOT_DEPTH - 1;
            end
            sm = spd < 0 ? -spd : spd;
            mag = (sm * (ONE_Q15 - cube_root[idx])) >> 15;
            if (mag < int'(cfg_min)) begin
                mag = int'(cfg_min);
            end
            slow = spd < 0 ? -mag : mag;
            if (err > 0) begin
                nl = slow;
                nr = spd;
                issue = 1'b1;
            end else if (err < 0) begin
                nl = spd;
                nr = slow;
                issue = 1'b1;
            end
            if (mag_err <= int'(dhk_pkg::NEAR_LIM)) begin
                near = 1'b1;
            end
        end
        if (issue) begin
            held_left = 9'(nl);
            held_right = 9'(nr);
        end
        res.left = held_left;
        res.right = held_right;
        res.issued = issue;
        res.on_tgt = near;
        return res;
    endfunction

    function automatic t_row cfg_row(logic [2:0] idx, logic [15:0] value);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.data = value;
        return row;
    endfunction

    function automatic t_row hdg_row(logic [15:0] h, bit typed, int l, int r, bit v, bit o);
        t_row row;
        row = '0;
        row.data = h;
        row.typed = typed;
        row.want.left = 9'(l);
        row.want.right = 9'(r);
        row.want.issued = v;
        row.want.on_tgt = o;
        return row;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk); while (pending_cmds.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Leaves the write valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dhk_pkg::CFG_OVERRIDE: cfg_override = value[0];
            dhk_pkg::CFG_TARGET:   cfg_target = value;
            dhk_pkg::CFG_CRUISE:   cfg_cruise = value[8:0];
            dhk_pkg::CFG_MIN:      cfg_min = value[7:0];
            dhk_pkg::CFG_TURN:     cfg_turn = value[7:0];
            default:               ;
        endcase
    endtask

    task automatic send_heading(logic signed [15:0] hdg, bit typed, t_cmd want);
        int   gap;
        t_cmd guess;
        gap = no_gaps ? 0 : int'($urandom_range(0, 7));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_heading  <= hdg;
        do @(posedge i_clk); while (o_in_stall);
        guess = steer_predict(hdg);
        pending_cmds.push_back(typed ? want : guess);
    endtask

    // Result side: random stalls, one long hold on request, and the comparison.
    initial begin : drain
        int   hold;
        t_cmd got;
        t_cmd want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = no_gaps ? 0 : int'($urandom_range(0, 7));
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            got.left = o_left_cmd;
            got.right = o_right_cmd;
            got.issued = o_cmd_valid;
            got.on_tgt = o_on_target;
            if (pending_cmds.size() == 0) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("tb: unexpected transfer left=%0d right=%0d cmd=%0b on=%0b",
                             got.left, got.right, got.issued, got.on_tgt);
                end
            end else begin
                want = pending_cmds.pop_front();
                if (got !== want) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display({"tb: mismatch at %0t: left %0d/%0d right %0d/%0d",
                                  " cmd %0b/%0b on %0b/%0b (exp/got)"},
                                 $realtime, want.left, got.left, want.right, got.right,
                                 want.issued, got.issued, want.on_tgt, got.on_tgt);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row              rows [$];
        t_cmd              none;
        longint unsigned   lower;
        longint unsigned   r;
        int                off;
        logic signed [15:0] hdg;
        logic signed [15:0] tgt;
        logic [8:0]        cruise;
        logic [7:0]        floor_spd;
        logic [7:0]        spin_spd;
        cfg_override = 1'b0;
        cfg_target = 16'sd16384;
        cfg_cruise = '0;
        cfg_min = '0;
        cfg_turn = 8'd255;
        held_left = '0;
        held_right = '0;
        none = '0;
        r = 0;
        for (int i = 0; i < dhk_pkg::ROOT_DEPTH; i++) begin
            lower = (64'(i) << 45) / 64'(6 * dhk_pkg::ROOT_DEPTH);
            while ((r + 1) * (r + 1) * (r + 1) <= lower) r++;
            cube_root[i] = int'(r);
        end

        // Reset state: target +1, turn-in-place mode at full turning speed.
        rows.push_back(hdg_row(16'sd16384, 1, 0, 0, 1, 1));
        rows.push_back(hdg_row(-16'sd16384, 1, 0, 0, 1, 1));
        rows.push_back(hdg_row(16'sd0, 1, -255, 255, 1, 0));
        rows.push_back(hdg_row(16'sd0, 1, -255, 255, 0, 0));
        rows.push_back(hdg_row(16'sd16184, 1, 255, -255, 1, 0));
        rows.push_back(hdg_row(16'sd16547, 1, 0, 0, 1, 1));
        rows.push_back(hdg_row(16'h8000, 1, -255, 255, 1, 0));
        rows.push_back(hdg_row(16'h7FFF, 1, -255, 255, 0, 0));
        rows.push_back(cfg_row(dhk_pkg::CFG_OVERRIDE, 16'd1));
        rows.push_back(hdg_row(16'sd0, 1, -255, 255, 0, 1));
        rows.push_back(cfg_row(dhk_pkg::CFG_OVERRIDE, 16'd0));
        rows.push_back(cfg_row(dhk_pkg::CFG_TARGET, 16'd0));
        rows.push_back(cfg_row(dhk_pkg::CFG_CRUISE, 16'd100));
        rows.push_back(cfg_row(dhk_pkg::CFG_TURN, 16'd200));
        rows.push_back(hdg_row(16'sd0, 1, -255, 255, 0, 1));
        rows.push_back(hdg_row(16'sd100, 0, 0, 0, 0, 0));
        rows.push_back(hdg_row(-16'sd100, 0, 0, 0, 0, 0));
        rows.push_back(hdg_row(16'sd9000, 1, -200, 200, 1, 0));
        rows.push_back(hdg_row(16'sd15000, 1, -200, 200, 0, 0));
        rows.push_back(hdg_row(-16'sd9000, 1, 200, -200, 1, 0));
        rows.push_back(hdg_row(16'sd8192, 0, 0, 0, 0, 0));
        // Most negative cruise speed saturates; the slowed side is floored at full speed.
        rows.push_back(cfg_row(dhk_pkg::CFG_CRUISE, 16'h0100));
        rows.push_back(cfg_row(dhk_pkg::CFG_MIN, 16'd255));
        rows.push_back(hdg_row(16'sd4000, 1, -255, -255, 1, 0));
        rows.push_back(hdg_row(16'sd16384, 1, -200, 200, 1, 0));
        rows.push_back(cfg_row(dhk_pkg::CFG_MIN, 16'd0));
        rows.push_back(cfg_row(dhk_pkg::CFG_CRUISE, 16'd255));
        rows.push_back(cfg_row(dhk_pkg::CFG_TURN, 16'd0));
        rows.push_back(cfg_row(dhk_pkg::CFG_TARGET, 16'hC001));
        rows.push_back(hdg_row(-16'sd16333, 0, 0, 0, 0, 0));
        rows.push_back(hdg_row(-16'sd16433, 0, 0, 0, 0, 0));
        rows.push_back(cfg_row(dhk_pkg::CFG_CRUISE, 16'd0));
        rows.push_back(hdg_row(16'sd0, 0, 0, 0, 0, 0));
        rows.push_back(hdg_row(-16'sd16000, 1, 0, 0, 1, 0));
        rows.push_back(hdg_row(16'sd16384, 1, 0, 0, 1, 1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                i_in_valid <= 1'b0;
                wait_idle();
                write_reg(rows[k].reg_idx, rows[k].data);
                i_cfg_valid <= 1'b0;
            end else begin
                send_heading(rows[k].data, rows[k].typed, rows[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       tgt = 16'sd16384;
                1:       tgt = -16'sd16383;
                2:       tgt = 16'($urandom);
                default: tgt = 16'(int'($urandom_range(0, 32767)) - 16383);
            endcase
            case ($urandom_range(0, 5))
                0:       cruise = 9'd0;
                1:       cruise = 9'h100;
                2:       cruise = 9'd255;
                3:       cruise = 9'h101;
                default: cruise = 9'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       floor_spd = 8'd0;
                1:       floor_spd = 8'd255;
                default: floor_spd = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       spin_spd = 8'd0;
                1:       spin_spd = 8'd255;
                default: spin_spd = 8'($urandom);
            endcase
            i_in_valid <= 1'b0;
            wait_idle();
            write_reg(dhk_pkg::CFG_OVERRIDE,
                      {15'($urandom), 1'(p == 2 || $urandom_range(0, 7) == 0)});
            write_reg(dhk_pkg::CFG_TARGET, tgt);
            write_reg(dhk_pkg::CFG_CRUISE, {7'($urandom), cruise});
            write_reg(dhk_pkg::CFG_MIN, {8'($urandom), floor_spd});
            write_reg(dhk_pkg::CFG_TURN, {8'($urandom), spin_spd});
            i_cfg_valid <= 1'b0;
            no_gaps = (p % 4 == 1);
            // One phase lets the result side back up so that the input stalls.
            if (p == 3) begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 3))
                    0:       off = int'($urandom_range(0, 400)) - 200;
                    1:       off = int'($urandom_range(0, 20000)) - 10000;
                    2:       off = int'($urandom);
                    default: off = 16384 + int'($urandom_range(0, 3400)) - 1700;
                endcase
                hdg = 16'(int'(cfg_target) + off);
                send_heading(hdg, 0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_count == 0 && pending_cmds.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dhk_pkg.sv
rtl/differential_heading_keeper_top.sv
dv/tb.sv
